/* rtl/core/punctuator_maximal_munch_lexer_defines.svh */
// assertion macros for the punctuator lexer
// used by the files that assert; needs nothing else
`ifndef PUNCTUATOR_MAXIMAL_MUNCH_LEXER_DEFINES_SVH
`define PUNCTUATOR_MAXIMAL_MUNCH_LEXER_DEFINES_SVH

// same-cycle implication, off during reset
`define PMML_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication, off during reset
`define PMML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

/* rtl/core/pmml_pkg.sv */
// constants and the operator extension table of the punctuator lexer
// standalone, used by punctuator_maximal_munch_lexer
package pmml_pkg;

  localparam int COLUMN_WIDTH = 16;
  localparam int COL_PORT_W   = 16;
  localparam int COL_KEEP     = (COLUMN_WIDTH < COL_PORT_W) ? COLUMN_WIDTH : COL_PORT_W;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // can the pending token take c as its next character
  function automatic logic can_extend(input logic [1:0] cnt, input logic [7:0] f,
                                      input logic [7:0] s, input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (cnt == CNT_ONE) begin
      case (f) inside
        CH_BANG, CH_PCT, CH_STAR, CH_SLASH, CH_EQ: ok = (c == CH_EQ);
        CH_HASH:  ok = (c == CH_HASH);
        CH_COLON: ok = (c == CH_COLON);
        CH_LBRK:  ok = (c == CH_LBRK);
        CH_RBRK:  ok = (c == CH_RBRK);
        CH_AMP:   ok = (c == CH_AMP) || (c == CH_EQ);
        CH_PLUS:  ok = (c == CH_PLUS) || (c == CH_EQ);
        CH_BAR:   ok = (c == CH_BAR) || (c == CH_EQ);
        CH_MINUS: ok = (c == CH_MINUS) || (c == CH_EQ) || (c == CH_GT);
        CH_DOT:   ok = (c == CH_DOT) || (c == CH_STAR);
        CH_LT:    ok = (c == CH_LT) || (c == CH_EQ);
        CH_GT:    ok = (c == CH_GT) || (c == CH_EQ);
        default:  ok = 1'b0;
      endcase
    end else if (cnt == CNT_TWO) begin
      if (f == CH_MINUS && s == CH_GT) ok = (c == CH_STAR);
      else if (f == CH_LT && s == CH_LT) ok = (c == CH_EQ);
      else if (f == CH_GT && s == CH_GT) ok = (c == CH_EQ);
    end
    return ok;
  endfunction

endpackage

/* rtl/core/punctuator_maximal_munch_lexer.sv */
// punctuator lexer: longest-match grouping of punctuation characters into operators
// depends on pmml_pkg and punctuator_maximal_munch_lexer_defines.svh
// a token is registered and offered on out_ in the cycle after the transfer of the item that closes it
// throughput: one input item per cycle while not stalled; the pending token register is the only loop
// input stalls only while the output register holds an untaken token
// reset (rst_n low, synchronous) clears the pending token and the output valid
`include "punctuator_maximal_munch_lexer_defines.svh"

module punctuator_maximal_munch_lexer
  import pmml_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [23:8] column
  input  logic [0:0]  in_tuser,   // [0] action (1 = boundary)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte,
                                  // [25:24] token_length, [41:26] token_column, rest zero
  output logic [0:0]  out_tuser   // [0] malformed
);

  logic [7:0]          pend_c0_r, pend_c1_r, pend_c2_r;
  logic [7:0]          pend_c0_nxt, pend_c1_nxt, pend_c2_nxt;
  logic [1:0]          pend_cnt_r, pend_cnt_nxt;
  logic [COL_KEEP-1:0] pend_start_r, pend_start_nxt;

  logic                out_valid_r;
  logic [7:0]          out_b0_r, out_b1_r, out_b2_r;
  logic [1:0]          out_len_r;
  logic [COL_KEEP-1:0] out_col_r;
  logic                out_bad_r;

  logic                in_xfer;
  logic                is_char;
  logic [7:0]          in_char;
  logic [COL_KEEP-1:0] in_col;
  logic                emit;
  logic [7:0]          emit_b0, emit_b1, emit_b2;
  logic [1:0]          emit_len;
  logic                emit_bad;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_char   = !in_tuser[0];
  assign in_char   = in_tdata[7:0];
  assign in_col    = in_tdata[8 +: COL_KEEP];

  always_comb begin
    pend_c0_nxt    = pend_c0_r;
    pend_c1_nxt    = pend_c1_r;
    pend_c2_nxt    = pend_c2_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_start_nxt = pend_start_r;
    emit     = 1'b0;
    emit_b0  = pend_c0_r;
    emit_b1  = (pend_cnt_r == CNT_TWO || pend_cnt_r == CNT_THREE) ? pend_c1_r : 8'd0;
    emit_b2  = (pend_cnt_r == CNT_THREE) ? pend_c2_r : 8'd0;
    emit_len = pend_cnt_r;
    emit_bad = 1'b0;
    if (in_xfer) begin
      if (pend_cnt_r == CNT_NONE) begin
        if (is_char) begin
          pend_c0_nxt    = in_char;
          pend_cnt_nxt   = CNT_ONE;
          pend_start_nxt = in_col;
        end
      end else if (pend_cnt_r == CNT_TWO && pend_c0_r == CH_DOT && pend_c1_r == CH_DOT) begin
        // '..' swallows whatever comes next as its third dot
        emit     = 1'b1;
        emit_b2  = CH_DOT;
        emit_len = CNT_THREE;
        emit_bad = !(is_char && in_char == CH_DOT);
        pend_c0_nxt    = 8'd0;
        pend_c1_nxt    = 8'd0;
        pend_c2_nxt    = 8'd0;
        pend_cnt_nxt   = CNT_NONE;
        pend_start_nxt = '0;
      end else if (is_char && can_extend(pend_cnt_r, pend_c0_r, pend_c1_r, in_char)) begin
        if (pend_cnt_r == CNT_ONE) pend_c1_nxt = in_char;
        else pend_c2_nxt = in_char;
        pend_cnt_nxt = pend_cnt_r + 2'd1;
      end else begin
        emit = 1'b1;
        pend_c1_nxt = 8'd0;
        pend_c2_nxt = 8'd0;
        if (is_char) begin
          pend_c0_nxt    = in_char;
          pend_cnt_nxt   = CNT_ONE;
          pend_start_nxt = in_col;
        end else begin
          pend_c0_nxt    = 8'd0;
          pend_cnt_nxt   = CNT_NONE;
          pend_start_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_c0_r    <= 8'd0;
      pend_c1_r    <= 8'd0;
      pend_c2_r    <= 8'd0;
      pend_cnt_r   <= CNT_NONE;
      pend_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_c0_r    <= pend_c0_nxt;
      pend_c1_r    <= pend_c1_nxt;
      pend_c2_r    <= pend_c2_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      pend_start_r <= pend_start_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_b0_r  <= emit_b0;
      out_b1_r  <= emit_b1;
      out_b2_r  <= emit_b2;
      out_len_r <= emit_len;
      out_col_r <= pend_start_r;
      out_bad_r <= emit_bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, COL_PORT_W'(out_col_r), out_len_r, out_b2_r, out_b1_r, out_b0_r};
  assign out_tuser  = out_bad_r;

  `PMML_ASSERT_NOW(a_len_nonzero, clk, rst_n, out_valid_r, out_len_r != CNT_NONE)
  `PMML_ASSERT_NOW(a_bad_is_dots, clk, rst_n, out_valid_r && out_bad_r,
                   out_len_r == CNT_THREE && out_b0_r == CH_DOT && out_b2_r == CH_DOT)
  `PMML_ASSERT_NEXT(a_three_closes, clk, rst_n, in_xfer && pend_cnt_r == CNT_THREE,
                    out_valid_r && pend_cnt_r != CNT_THREE)
  `PMML_ASSERT_NEXT(a_idle_boundary, clk, rst_n,
                    in_xfer && pend_cnt_r == CNT_NONE && in_tuser[0],
                    pend_cnt_r == CNT_NONE)
  `PMML_ASSERT_NOW(a_no_drop, clk, rst_n, emit && out_valid_r, out_tready)

endmodule

/* test/punctuator_token_checker.sv */
// token checker for punctuator_maximal_munch_lexer: predicts tokens from input transfers
// and compares them with output transfers; depends on pmml_pkg only
`timescale 1ns / 100ps

module punctuator_token_checker
  import pmml_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [23:8] column
  input  logic [0:0]  in_tuser,   // [0] action (1 = boundary)
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [7:0] first, [15:8] second, [23:16] third,
                                  // [25:24] length, [41:26] column
  input  logic [0:0]  out_tuser,  // [0] malformed
  output int          failures,
  output int          tokens_waiting
);

  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [7:0]  mid_byte;
    logic [7:0]  tail_byte;
    logic [1:0]  len;
    logic [15:0] col;
    logic        bad;
  } token_t;

  localparam logic [15:0] COL_MASK = 16'((32'd1 << COL_KEEP) - 1);

  logic [7:0]  held [3];
  logic [1:0]  held_cnt;
  logic [15:0] held_col;
  token_t      tokens_due [$];

  // longest-match table: can the held token absorb c
  function automatic logic grows_with(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (held_cnt == CNT_ONE) begin
      case (held[0])
        CH_BANG, CH_PCT, CH_STAR, CH_SLASH, CH_EQ: ok = (c == CH_EQ);
        CH_HASH:  ok = (c == CH_HASH);
        CH_COLON: ok = (c == CH_COLON);
        CH_LBRK:  ok = (c == CH_LBRK);
        CH_RBRK:  ok = (c == CH_RBRK);
        CH_AMP:   ok = (c == CH_AMP) || (c == CH_EQ);
        CH_PLUS:  ok = (c == CH_PLUS) || (c == CH_EQ);
        CH_BAR:   ok = (c == CH_BAR) || (c == CH_EQ);
        CH_MINUS: ok = (c == CH_MINUS) || (c == CH_EQ) || (c == CH_GT);
        CH_DOT:   ok = (c == CH_DOT) || (c == CH_STAR);
        CH_LT:    ok = (c == CH_LT) || (c == CH_EQ);
        CH_GT:    ok = (c == CH_GT) || (c == CH_EQ);
        default:  ok = 1'b0;
      endcase
    end else if (held_cnt == CNT_TWO) begin
      if (held[0] == CH_MINUS && held[1] == CH_GT) ok = (c == CH_STAR);
      else if (held[0] == CH_LT && held[1] == CH_LT) ok = (c == CH_EQ);
      else if (held[0] == CH_GT && held[1] == CH_GT) ok = (c == CH_EQ);
    end
    return ok;
  endfunction

  task automatic drop_held();
    held[0] = 8'h00;
    held[1] = 8'h00;
    held[2] = 8'h00;
    held_cnt = CNT_NONE;
    held_col = 16'h0000;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [15:0] col);
    drop_held();
    held[0] = c;
    held_cnt = CNT_ONE;
    held_col = col & COL_MASK;
  endtask

  task automatic close_token(input logic bad);
    token_t tok;
    tok.lead_byte = held[0];
    tok.mid_byte  = (held_cnt >= CNT_TWO) ? held[1] : 8'h00;
    tok.tail_byte = (held_cnt == CNT_THREE) ? held[2] : 8'h00;
    tok.len       = held_cnt;
    tok.col       = held_col;
    tok.bad       = bad;
    tokens_due.push_back(tok);
  endtask

  task automatic lex_item(input logic boundary, input logic [7:0] c, input logic [15:0] col);
    if (held_cnt == CNT_NONE) begin
      if (!boundary) open_token(c, col);
    end else if (held_cnt == CNT_TWO && held[0] == CH_DOT && held[1] == CH_DOT) begin
      // '..' swallows whatever comes next and always reads as '...'
      held[2] = CH_DOT;
      held_cnt = CNT_THREE;
      close_token(!(!boundary && c == CH_DOT));
      drop_held();
    end else if (!boundary && held_cnt != CNT_THREE && grows_with(c)) begin
      held[held_cnt] = c;
      held_cnt = held_cnt + 2'd1;
    end else begin
      close_token(1'b0);
      if (!boundary) open_token(c, col);
      else drop_held();
    end
  endtask

  task automatic match_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      drop_held();
      tokens_due.delete();
    end else begin
      // a token leaving now was closed by an earlier input transfer
      if (out_tvalid && out_tready) begin
        if (tokens_due.size() == 0) begin
          $error("token transfer with none expected: %h", out_tdata);
          failures++;
        end else begin
          want = tokens_due.pop_front();
          match_field("first_byte", 16'(want.lead_byte), 16'(out_tdata[7:0]));
          match_field("second_byte", 16'(want.mid_byte), 16'(out_tdata[15:8]));
          match_field("third_byte", 16'(want.tail_byte), 16'(out_tdata[23:16]));
          match_field("token_length", 16'(want.len), 16'(out_tdata[25:24]));
          match_field("token_column", want.col, out_tdata[41:26]);
          match_field("malformed", 16'(want.bad), 16'(out_tuser[0]));
        end
      end
      if (in_tvalid && in_tready) lex_item(in_tuser[0], in_tdata[7:0], in_tdata[23:8]);
    end
    tokens_waiting = tokens_due.size();
  end

endmodule

/* test/punctuator_maximal_munch_lexer_tb.sv */
// testbench top for punctuator_maximal_munch_lexer: directed and random character streams,
// bursty input and stalling output; depends on pmml_pkg and punctuator_token_checker
`timescale 1ns / 100ps

module punctuator_maximal_munch_lexer_tb;
  import pmml_pkg::*;

  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   ITEM_TARGET  = 750;
  localparam logic ACT_CHAR     = 1'b0;
  localparam logic ACT_BOUNDARY = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  int          failures;
  int          tokens_waiting;
  int unsigned cyc = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  bit          after_char = 1'b0;
  logic [15:0] col_now = 16'h0000;
  int          stall_mode = 0;
  int          stall_phase = 0;

  string operators [27] = '{"!=", "##", "%=", "&&", "&=", "*=", "++", "+=", "--", "-=",
                            "->", "->*", ".*", "...", "/=", "::", "<=", "<<", "<<=",
                            "==", ">=", ">>", ">>=", "||", "|=", "[[", "]]"};
  string singles = "!#%&*+-./:<=>[]|(){};,?~^@";

  punctuator_maximal_munch_lexer uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  punctuator_token_checker token_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .failures(failures), .tokens_waiting(tokens_waiting)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: phases of always ready, coin flip, mostly stalled, fixed duty pattern
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 120);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((cyc % 7) < 4);
    endcase
  end

  task automatic send_item(input logic act, input logic [7:0] ch, input logic [15:0] col);
    int gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {col, ch};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    // a boundary that does not follow a character finds nothing pending, so it is not counted
    if (act == ACT_CHAR || after_char) items_sent++;
    after_char = (act == ACT_CHAR);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(ACT_CHAR, s[i], col_now);
      col_now++;
    end
  endtask

  initial begin : stimulus
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty boundary, byte and column extremes, three-char tokens, double dot cases
    send_item(ACT_BOUNDARY, 8'h41, 16'h0000);
    send_item(ACT_CHAR, 8'h00, 16'h0000);
    send_item(ACT_CHAR, 8'hFF, 16'hFFFF);
    send_item(ACT_BOUNDARY, 8'h00, 16'h0001);
    col_now = 16'd10;
    send_text("->*");
    send_text("<<=");
    send_text("...");
    send_text("..");
    send_item(ACT_CHAR, 8'h78, col_now);
    send_text("..");
    send_item(ACT_BOUNDARY, 8'h20, col_now);
    send_text(".*");
    send_text(">>=");
    send_item(ACT_CHAR, 8'h61, col_now);
    send_item(ACT_BOUNDARY, 8'h61, col_now);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) col_now = 16'($urandom_range(0, 65535));
      if (pick < 60) begin
        send_text(operators[$urandom_range(0, 26)]);
        if ($urandom_range(0, 1)) send_item(ACT_BOUNDARY, 8'($urandom_range(0, 255)), col_now);
      end else if (pick < 75) begin
        send_item(ACT_CHAR, singles[$urandom_range(0, singles.len() - 1)], col_now);
      end else if (pick < 85) begin
        send_item(ACT_CHAR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end else if (pick < 93) begin
        send_text("..");
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), col_now);
      end else begin
        send_item(ACT_BOUNDARY, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
      col_now = col_now + 16'($urandom_range(0, 2));
    end
    // flush whatever token is still held
    send_item(ACT_BOUNDARY, 8'h20, col_now);
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (tokens_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pmml_pkg.sv
rtl/core/punctuator_maximal_munch_lexer.sv
test/punctuator_token_checker.sv
test/punctuator_maximal_munch_lexer_tb.sv
